// File: hdl/lsat_pkg.sv
// Package: command codes, controller states and fixed field widths of the LRU tag array.
package lsat_pkg;

    // Fixed widths of the command fields
    localparam int CMD_BITS       = 3;
    localparam int SET_INDEX_BITS = 6;
    localparam int SET_IN_RANGE   = 1 << SET_INDEX_BITS;

    // Command codes
    typedef enum logic [CMD_BITS-1:0] {
        CMD_LOOKUP    = 3'd0,
        CMD_INSERT    = 3'd1,
        CMD_DIRTY     = 3'd2,
        CMD_INVAL     = 3'd3,
        CMD_SET_STATE = 3'd4,
        CMD_GET_STATE = 3'd5
    } cmd_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } ctrl_state_t;

endpackage

// File: hdl/lsat_req_if.sv
// Interfaces: command channel and response channel of the LRU tag array.
interface lsat_req_if #(
    parameter int TAG_BITS   = 20,
    parameter int STATE_BITS = 3
);
    logic                  valid;
    logic                  ready;
    logic [2:0]            cmd;
    logic [5:0]            set_index;
    logic [TAG_BITS-1:0]   tag;
    logic [STATE_BITS-1:0] state_value;

    modport source (output valid, cmd, set_index, tag, state_value, input ready);
    modport sink   (input valid, cmd, set_index, tag, state_value, output ready);
endinterface

interface lsat_rsp_if #(
    parameter int STATE_BITS = 3
);
    logic                  valid;
    logic                  ready;
    logic                  hit;
    logic                  write_back;
    logic [STATE_BITS-1:0] state_out;

    modport source (output valid, hit, write_back, state_out, input ready);
    modport sink   (input valid, hit, write_back, state_out, output ready);
endinterface

// File: hdl/lsat_row_mem.sv
// Set memory: one row per cache set, one write port and one registered read port.
module lsat_row_mem #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 111,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/lsat_set_update.sv
// Set update: applies one command to a set row and forms the response fields.
module lsat_set_update #(
    parameter int WAYS       = 4,
    parameter int TAG_BITS   = 20,
    parameter int STATE_BITS = 3,
    parameter int RANK_W     = 2,
    parameter int FILL_W     = 3,
    parameter int ROW_W      = 111
) (
    input  logic [2:0]            cmd,
    input  logic [TAG_BITS-1:0]   tag,
    input  logic [STATE_BITS-1:0] state_value,
    input  logic [ROW_W-1:0]      row_in,
    output logic [ROW_W-1:0]      row_out,
    output logic                  hit,
    output logic                  write_back,
    output logic [STATE_BITS-1:0] state_out
);

    import lsat_pkg::*;

    localparam int WAY_FW = TAG_BITS + 3 + STATE_BITS + RANK_W;
    localparam int OFS_V  = TAG_BITS;
    localparam int OFS_D  = TAG_BITS + 1;
    localparam int OFS_C  = TAG_BITS + 2;
    localparam int OFS_R  = TAG_BITS + 2 + STATE_BITS;
    localparam int FILL_O = WAYS * WAY_FW;

    logic [TAG_BITS-1:0]   w_tag   [WAYS];
    logic                  w_valid [WAYS];
    logic                  w_dirty [WAYS];
    logic [STATE_BITS-1:0] w_coh   [WAYS];
    logic [RANK_W-1:0]     w_rank  [WAYS];
    logic [FILL_W-1:0]     fill;

    logic [TAG_BITS-1:0]   n_tag   [WAYS];
    logic                  n_valid [WAYS];
    logic                  n_dirty [WAYS];
    logic [STATE_BITS-1:0] n_coh   [WAYS];
    logic [RANK_W-1:0]     n_rank  [WAYS];
    logic [FILL_W-1:0]     n_fill;

    logic [WAYS-1:0] occ;
    logic [WAYS-1:0] is_mru;
    logic [WAYS-1:0] match;
    logic [WAYS-1:0] is_best;
    logic [WAYS-1:0] is_lru;

    // Unpack the row
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            w_tag[w]   = row_in[w*WAY_FW +: TAG_BITS];
            w_valid[w] = row_in[w*WAY_FW + OFS_V];
            w_dirty[w] = row_in[w*WAY_FW + OFS_D];
            w_coh[w]   = row_in[w*WAY_FW + OFS_C +: STATE_BITS];
            w_rank[w]  = row_in[w*WAY_FW + OFS_R +: RANK_W];
        end
        fill = row_in[FILL_O +: FILL_W];
    end

    // Classify ways: occupied, MRU, LRU, tag match
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            occ[w]    = (FILL_W'(w) < fill);
            is_mru[w] = occ[w] && (w_rank[w] == '0);
            is_lru[w] = occ[w] && (w_rank[w] == RANK_W'(WAYS - 1));
            match[w]  = occ[w] && w_valid[w] && (w_tag[w] == tag);
        end
    end

    // Pick the matching way closest to MRU
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            is_best[w] = match[w];
            for (int v = 0; v < WAYS; v++)
            begin
                if (v != w && match[v] && (w_rank[v] < w_rank[w]))
                begin
                    is_best[w] = 1'b0;
                end
            end
        end
    end

    // Apply the command
    always_comb
    begin
        logic             full;
        logic [WAYS-1:0]  target;
        logic [RANK_W:0]  r_eff;
        logic             found;

        for (int w = 0; w < WAYS; w++)
        begin
            n_tag[w]   = w_tag[w];
            n_valid[w] = w_valid[w];
            n_dirty[w] = w_dirty[w];
            n_coh[w]   = w_coh[w];
            n_rank[w]  = w_rank[w];
        end
        n_fill     = fill;
        hit        = 1'b0;
        write_back = 1'b0;
        state_out  = '0;
        full       = (fill >= FILL_W'(WAYS));
        target     = '0;
        r_eff      = '0;
        found      = 1'b0;

        case (cmd)
            CMD_LOOKUP:
            begin
                hit = |match;
                for (int w = 0; w < WAYS; w++)
                begin
                    if (is_best[w])
                    begin
                        r_eff = {1'b0, w_rank[w]};
                    end
                end
                if (hit)
                begin
                    for (int w = 0; w < WAYS; w++)
                    begin
                        if (is_best[w])
                        begin
                            n_rank[w] = '0;
                        end
                        else if (occ[w] && ({1'b0, w_rank[w]} < r_eff))
                        begin
                            n_rank[w] = w_rank[w] + 1'b1;
                        end
                    end
                end
            end
            CMD_INSERT:
            begin
                // Choose the free way or the LRU way (way 0 if none ranks last)
                if (!full)
                begin
                    for (int w = 0; w < WAYS; w++)
                    begin
                        target[w] = (FILL_W'(w) == fill);
                    end
                    r_eff  = (RANK_W+1)'(fill);
                    n_fill = fill + 1'b1;
                end
                else
                begin
                    for (int w = 0; w < WAYS; w++)
                    begin
                        if (is_lru[w] && !found)
                        begin
                            target[w] = 1'b1;
                            found     = 1'b1;
                        end
                    end
                    if (!found)
                    begin
                        target[0] = 1'b1;
                    end
                    for (int w = 0; w < WAYS; w++)
                    begin
                        if (target[w])
                        begin
                            r_eff      = {1'b0, w_rank[w]};
                            write_back = w_valid[w] && w_dirty[w];
                        end
                    end
                end
                // Fill the way and make it MRU
                for (int w = 0; w < WAYS; w++)
                begin
                    if (target[w])
                    begin
                        n_tag[w]   = tag;
                        n_valid[w] = 1'b1;
                        n_dirty[w] = 1'b0;
                        n_coh[w]   = '0;
                        n_rank[w]  = '0;
                    end
                    else if (occ[w] && ({1'b0, w_rank[w]} < r_eff))
                    begin
                        n_rank[w] = w_rank[w] + 1'b1;
                    end
                end
            end
            CMD_DIRTY:
            begin
                for (int w = 0; w < WAYS; w++)
                begin
                    if (is_mru[w])
                    begin
                        n_dirty[w] = 1'b1;
                    end
                end
            end
            CMD_INVAL:
            begin
                // Drop the MRU way to LRU, move the others up
                if (|is_mru)
                begin
                    for (int w = 0; w < WAYS; w++)
                    begin
                        if (is_mru[w])
                        begin
                            n_valid[w] = 1'b0;
                            n_rank[w]  = RANK_W'(fill - 1'b1);
                        end
                        else if (occ[w] && (w_rank[w] != '0))
                        begin
                            n_rank[w] = w_rank[w] - 1'b1;
                        end
                    end
                end
            end
            CMD_SET_STATE:
            begin
                for (int w = 0; w < WAYS; w++)
                begin
                    if (is_mru[w])
                    begin
                        n_coh[w] = state_value;
                    end
                end
            end
            CMD_GET_STATE:
            begin
                for (int w = 0; w < WAYS; w++)
                begin
                    if (is_mru[w])
                    begin
                        state_out = w_coh[w];
                    end
                end
            end
            default:
            begin
                n_fill = fill;
            end
        endcase
    end

    // Pack the row
    always_comb
    begin
        row_out = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            row_out[w*WAY_FW +: TAG_BITS]           = n_tag[w];
            row_out[w*WAY_FW + OFS_V]               = n_valid[w];
            row_out[w*WAY_FW + OFS_D]               = n_dirty[w];
            row_out[w*WAY_FW + OFS_C +: STATE_BITS] = n_coh[w];
            row_out[w*WAY_FW + OFS_R +: RANK_W]     = n_rank[w];
        end
        row_out[FILL_O +: FILL_W] = n_fill;
    end

endmodule

// File: hdl/lru_set_assoc_tag_array_top.sv
// Top level: set-associative tag array with true LRU order per set.
//
// req carries one command per transaction (lookup, insert, mark dirty,
// invalidate, set state, get state) for one set; rsp returns exactly one
// response per command, in order. Both channels are valid/ready.
// Each set lives in one row of a synchronous memory. A command reads its
// row on the accept edge, updates it in ST_EXEC and, once the response
// register is free, writes it back while loading that register, from
// which rsp.valid is driven. Because of the read-modify-write of the set
// row, req.ready is high only while no command is being executed.
// After reset the block sweeps the memory and writes every row empty, one
// row a cycle, with req.ready low.
// When rsp stalls, the response register holds; one more command may be
// accepted and waits with its set row read until the register frees.
module lru_set_assoc_tag_array_top #(
    parameter int NUM_SETS   = 64,
    parameter int WAYS       = 4,
    parameter int TAG_BITS   = 20,
    parameter int STATE_BITS = 3
) (
    input  logic       clk,
    input  logic       rst_n,
    lsat_req_if.sink   req,
    lsat_rsp_if.source rsp
);

    import lsat_pkg::*;

    localparam int IDX_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int FILL_W = $clog2(WAYS + 1);
    localparam int WAY_FW = TAG_BITS + 3 + STATE_BITS + RANK_W;
    localparam int ROW_W  = WAYS * WAY_FW + FILL_W;

    typedef logic [SET_IN_RANGE-1:0][IDX_W-1:0] set_map_t;

    // Reduce the incoming set index modulo NUM_SETS
    function automatic set_map_t build_set_map();
        set_map_t m;
        int       r;
        r = 0;
        for (int i = 0; i < SET_IN_RANGE; i++)
        begin
            m[i] = IDX_W'(r);
            r    = (r == NUM_SETS - 1) ? 0 : r + 1;
        end
        return m;
    endfunction

    localparam set_map_t SET_MAP = build_set_map();

    ctrl_state_t state_reg, state_next;
    logic [IDX_W-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [IDX_W-1:0]      set_reg;
    logic [2:0]            cmd_reg;
    logic [TAG_BITS-1:0]   tag_reg;
    logic [STATE_BITS-1:0] sv_reg;
    logic                  out_valid_reg, out_valid_next;
    logic                  hit_reg;
    logic                  wb_reg;
    logic [STATE_BITS-1:0] st_reg;

    logic                  accept;
    logic                  out_free;
    logic                  finish;
    logic                  mem_wr_en;
    logic [IDX_W-1:0]      mem_wr_addr;
    logic [ROW_W-1:0]      mem_wr_data;
    logic [ROW_W-1:0]      mem_rd_data;
    logic [ROW_W-1:0]      row_upd;
    logic                  upd_hit;
    logic                  upd_wb;
    logic [STATE_BITS-1:0] upd_st;

    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;
    assign finish   = (state_reg == ST_EXEC) && out_free;

    // Next state
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == IDX_W'(NUM_SETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Outputs of the controller
    always_comb
    begin
        req.ready   = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = set_reg;
        mem_wr_data = row_upd;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = clr_cnt_reg;
                mem_wr_data = '0;
            end
            ST_IDLE:
            begin
                req.ready = 1'b1;
            end
            ST_EXEC:
            begin
                mem_wr_en = out_free;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the accepted command
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            set_reg <= SET_MAP[req.set_index];
            cmd_reg <= req.cmd;
            tag_reg <= req.tag;
            sv_reg  <= req.state_value;
        end
    end

    // Response register
    always_comb
    begin
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            hit_reg <= upd_hit;
            wb_reg  <= upd_wb;
            st_reg  <= upd_st;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.hit        = hit_reg;
    assign rsp.write_back = wb_reg;
    assign rsp.state_out  = st_reg;

    lsat_row_mem #(
        .DEPTH  (NUM_SETS),
        .WIDTH  (ROW_W),
        .ADDR_W (IDX_W)
    ) u_row_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (accept),
        .rd_addr (SET_MAP[req.set_index]),
        .rd_data (mem_rd_data)
    );

    lsat_set_update #(
        .WAYS       (WAYS),
        .TAG_BITS   (TAG_BITS),
        .STATE_BITS (STATE_BITS),
        .RANK_W     (RANK_W),
        .FILL_W     (FILL_W),
        .ROW_W      (ROW_W)
    ) u_set_update (
        .cmd         (cmd_reg),
        .tag         (tag_reg),
        .state_value (sv_reg),
        .row_in      (mem_rd_data),
        .row_out     (row_upd),
        .hit         (upd_hit),
        .write_back  (upd_wb),
        .state_out   (upd_st)
    );

endmodule
